[rtl/core/ldp_pkg.sv]
// Shared types, constants and arithmetic helpers of the lens distortion projection block.
package ldp_pkg;

	typedef logic signed [63:0] q_t;

	// Saturation limit of every intermediate value.
	localparam q_t LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam q_t Q28_ONE = 64'sh0000_0000_1000_0000;
	localparam logic signed [64:0] SUM_HI = 65'sh0_3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] SUM_LO = -SUM_HI;

	// The numerator of the normalizing divide is |x| followed by 28 zero bits.
	localparam int FRAC_W = 28;
	localparam int NUM_W = 32 + FRAC_W;
	localparam int REM_W = 31;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BEHIND = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_K1 = 3'd0,
		REG_K2 = 3'd1,
		REG_K3 = 3'd2,
		REG_P1 = 3'd3,
		REG_P2 = 3'd4,
		REG_FX = 3'd5,
		REG_FY = 3'd6,
		REG_PP = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic ovf;
		q_t val;
	} sat_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [NUM_W-1:0] num;
	} dstep_t;

	typedef struct packed {
		logic behind;
		logic xneg;
		logic yneg;
	} div_tag_t;

	typedef struct packed {
		logic valid;
		logic behind;
		q_t xn;
		q_t yn;
	} div_out_t;

	function automatic sat_t sadd(q_t a, q_t b);
		logic signed [64:0] s;
		sat_t r;
		s = {a[63], a} + {b[63], b};
		r.ovf = 1'b0;
		r.val = s[63:0];
		if (s > SUM_HI) begin
			r.ovf = 1'b1;
			r.val = LIM;
		end else if (s < SUM_LO) begin
			r.ovf = 1'b1;
			r.val = -LIM;
		end
		return r;
	endfunction

	// One step of restoring division: the numerator shifts left and takes the quotient bit.
	function automatic dstep_t div_step(logic [REM_W-1:0] rem, logic [NUM_W-1:0] num,
		logic [REM_W-1:0] d);
		logic [REM_W:0] trial;
		logic [REM_W:0] diff;
		logic ge;
		dstep_t r;
		trial = {rem, num[NUM_W-1]};
		diff = trial - {1'b0, d};
		ge = trial >= {1'b0, d};
		r.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
		r.num = {num[NUM_W-2:0], ge};
		return r;
	endfunction

endpackage

[rtl/core/lens_distortion_projection.sv]
// Throughput: one point per cycle; 61 stages of the divider and 32 arithmetic stages
// advance together whenever the output skid stage is empty.
// Reset: arst_n clears all valid bits and loads the default coefficients and focal lengths.
// The output register and one skid word let the pipeline run while a result waits.
module lens_distortion_projection (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pixel_u,
	output logic signed [31:0] pixel_v,
	output logic [1:0]         status,
	input  logic               cfg_wr,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	localparam int NPOST = 32;
	localparam int NMUL = 16;

	typedef struct packed {
		logic              behind;
		logic              ovf;
		ldp_pkg::q_t       xn;
		ldp_pkg::q_t       yn;
		ldp_pkg::q_t       xy;
		ldp_pkg::q_t       r2;
		ldp_pkg::q_t       xx2;
		ldp_pkg::q_t       yy2;
		ldp_pkg::q_t       a2x;
		ldp_pkg::q_t       a2y;
		ldp_pkg::q_t       r4;
		ldp_pkg::q_t       r6;
		ldp_pkg::q_t       f;
		ldp_pkg::q_t       xd;
		ldp_pkg::q_t       yd;
		ldp_pkg::q_t       tx;
		ldp_pkg::q_t       ty;
		ldp_pkg::q_t       u;
		ldp_pkg::q_t       v;
		logic [31:0]       pu;
		logic [31:0]       pv;
		ldp_pkg::status_t  st;
	} pp_t;

	logic [31:0] k1_q;
	logic [31:0] k2_q;
	logic [31:0] k3_q;
	logic [31:0] p1_q;
	logic [31:0] p2_q;
	logic [31:0] fx_q;
	logic [31:0] fy_q;
	logic [63:0] pp_q;

	logic              en;
	ldp_pkg::div_out_t div_o;
	pp_t               p0;
	pp_t               pp_s  [1:NPOST];
	logic              vld_s [1:NPOST];
	pp_t               nxt   [1:NPOST];

	ldp_pkg::q_t ma  [NMUL];
	ldp_pkg::q_t mb  [NMUL];
	ldp_pkg::q_t mp  [NMUL];
	logic        mo  [NMUL];

	ldp_pkg::q_t k1s, k2s, k3s, p1s, p2s, p1x2, p2x2, fxs, fys, cxs, cys;

	ldp_pkg::sat_t r2_c, xx2_c, yy2_c, a2x_c, a2y_c, f10_c, f15_c, f20_c;
	ldp_pkg::sat_t xd25_c, yd25_c, xd26_c, yd26_c, u_c, v_c;
	logic          fit_u, fit_v;
	logic [31:0]   pu_c, pv_c;

	logic              out_valid_q;
	logic              skid_valid_q;
	logic signed [31:0] pixel_u_q, pixel_v_q, skid_u_q, skid_v_q;
	logic [1:0]        status_q, skid_st_q;
	logic              out_load;
	logic              emit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= '0;
			k2_q <= '0;
			k3_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
			fx_q <= 32'h03E8_0000;
			fy_q <= 32'h03E8_0000;
			pp_q <= '0;
		end else if (cfg_wr) begin
			case (ldp_pkg::reg_idx_t'(cfg_index))
				ldp_pkg::REG_K1: k1_q <= cfg_data[31:0];
				ldp_pkg::REG_K2: k2_q <= cfg_data[31:0];
				ldp_pkg::REG_K3: k3_q <= cfg_data[31:0];
				ldp_pkg::REG_P1: p1_q <= cfg_data[31:0];
				ldp_pkg::REG_P2: p2_q <= cfg_data[31:0];
				ldp_pkg::REG_FX: fx_q <= cfg_data[31:0];
				ldp_pkg::REG_FY: fy_q <= cfg_data[31:0];
				ldp_pkg::REG_PP: pp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign k1s = {{32{k1_q[31]}}, k1_q};
	assign k2s = {{32{k2_q[31]}}, k2_q};
	assign k3s = {{32{k3_q[31]}}, k3_q};
	assign p1s = {{32{p1_q[31]}}, p1_q};
	assign p2s = {{32{p2_q[31]}}, p2_q};
	assign p1x2 = {{31{p1_q[31]}}, p1_q, 1'b0};
	assign p2x2 = {{31{p2_q[31]}}, p2_q, 1'b0};
	assign fxs = {32'b0, fx_q};
	assign fys = {32'b0, fy_q};
	// The principal point drops its low four bits to become Q.12.
	assign cxs = {36'b0, pp_q[31:4]};
	assign cys = {36'b0, pp_q[63:36]};

	// The whole pipeline advances unless the skid word is occupied.
	assign en = !skid_valid_q;
	assign in_stall = skid_valid_q;

	ldp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.x        (point_x),
		.y        (point_y),
		.z        (point_z),
		.res      (div_o)
	);

	always_comb begin
		p0 = '0;
		p0.behind = div_o.behind;
		p0.xn = div_o.xn;
		p0.yn = div_o.yn;
	end

	// Multiplier operands; each result lines up with the stage four registers later.
	assign ma[0] = p0.xn;        assign mb[0] = p0.xn;
	assign ma[1] = p0.yn;        assign mb[1] = p0.yn;
	assign ma[2] = p0.xn;        assign mb[2] = p0.yn;
	assign ma[3] = pp_s[5].r2;   assign mb[3] = pp_s[5].r2;
	assign ma[4] = k1s;          assign mb[4] = pp_s[5].r2;
	assign ma[5] = pp_s[10].r2;  assign mb[5] = pp_s[10].r4;
	assign ma[6] = k2s;          assign mb[6] = pp_s[10].r4;
	assign ma[7] = k3s;          assign mb[7] = pp_s[15].r6;
	assign ma[8] = pp_s[20].xn;  assign mb[8] = pp_s[20].f;
	assign ma[9] = pp_s[20].yn;  assign mb[9] = pp_s[20].f;
	assign ma[10] = p1x2;        assign mb[10] = pp_s[20].xy;
	assign ma[11] = p2s;         assign mb[11] = pp_s[20].a2x;
	assign ma[12] = p1s;         assign mb[12] = pp_s[20].a2y;
	assign ma[13] = p2x2;        assign mb[13] = pp_s[20].xy;
	assign ma[14] = fxs;         assign mb[14] = pp_s[26].xd;
	assign ma[15] = fys;         assign mb[15] = pp_s[26].yd;

	for (genvar m = 0; m < NMUL; m++) begin : g_mul
		ldp_mul u_mul (
			.clk  (clk),
			.en   (en),
			.wide (m >= 14 ? 1'b1 : 1'b0),
			.a    (ma[m]),
			.b    (mb[m]),
			.p    (mp[m]),
			.ovf  (mo[m])
		);
	end

	assign r2_c = ldp_pkg::sadd(mp[0], mp[1]);
	assign xx2_c = ldp_pkg::sadd(mp[0], mp[0]);
	assign yy2_c = ldp_pkg::sadd(mp[1], mp[1]);
	assign a2x_c = ldp_pkg::sadd(pp_s[5].r2, pp_s[5].xx2);
	assign a2y_c = ldp_pkg::sadd(pp_s[5].r2, pp_s[5].yy2);
	assign f10_c = ldp_pkg::sadd(ldp_pkg::Q28_ONE, mp[4]);
	assign f15_c = ldp_pkg::sadd(pp_s[14].f, mp[6]);
	assign f20_c = ldp_pkg::sadd(pp_s[19].f, mp[7]);
	assign xd25_c = ldp_pkg::sadd(mp[8], mp[10]);
	assign yd25_c = ldp_pkg::sadd(mp[9], mp[12]);
	assign xd26_c = ldp_pkg::sadd(pp_s[25].xd, pp_s[25].tx);
	assign yd26_c = ldp_pkg::sadd(pp_s[25].yd, pp_s[25].ty);
	assign u_c = ldp_pkg::sadd(mp[14], cxs);
	assign v_c = ldp_pkg::sadd(mp[15], cys);

	assign fit_u = pp_s[31].u[63:31] == {33{pp_s[31].u[63]}};
	assign fit_v = pp_s[31].v[63:31] == {33{pp_s[31].v[63]}};
	assign pu_c = fit_u ? pp_s[31].u[31:0] : (pp_s[31].u[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);
	assign pv_c = fit_v ? pp_s[31].v[31:0] : (pp_s[31].v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);

	always_comb begin
		for (int i = 1; i <= NPOST; i++) begin
			if (i == 1) begin
				nxt[i] = p0;
			end else begin
				nxt[i] = pp_s[i-1];
			end
			case (i)
				5: begin
					nxt[i].xy = mp[2];
					nxt[i].r2 = r2_c.val;
					nxt[i].xx2 = xx2_c.val;
					nxt[i].yy2 = yy2_c.val;
					nxt[i].ovf = pp_s[i-1].ovf | mo[0] | mo[1] | mo[2] | r2_c.ovf
						| xx2_c.ovf | yy2_c.ovf;
				end
				6: begin
					nxt[i].a2x = a2x_c.val;
					nxt[i].a2y = a2y_c.val;
					nxt[i].ovf = pp_s[i-1].ovf | a2x_c.ovf | a2y_c.ovf;
				end
				10: begin
					nxt[i].r4 = mp[3];
					nxt[i].f = f10_c.val;
					nxt[i].ovf = pp_s[i-1].ovf | mo[3] | mo[4] | f10_c.ovf;
				end
				15: begin
					nxt[i].r6 = mp[5];
					nxt[i].f = f15_c.val;
					nxt[i].ovf = pp_s[i-1].ovf | mo[5] | mo[6] | f15_c.ovf;
				end
				20: begin
					nxt[i].f = f20_c.val;
					nxt[i].ovf = pp_s[i-1].ovf | mo[7] | f20_c.ovf;
				end
				25: begin
					nxt[i].xd = xd25_c.val;
					nxt[i].yd = yd25_c.val;
					nxt[i].tx = mp[11];
					nxt[i].ty = mp[13];
					nxt[i].ovf = pp_s[i-1].ovf | mo[8] | mo[9] | mo[10] | mo[11] | mo[12]
						| mo[13] | xd25_c.ovf | yd25_c.ovf;
				end
				26: begin
					nxt[i].xd = xd26_c.val;
					nxt[i].yd = yd26_c.val;
					nxt[i].ovf = pp_s[i-1].ovf | xd26_c.ovf | yd26_c.ovf;
				end
				31: begin
					nxt[i].u = u_c.val;
					nxt[i].v = v_c.val;
					nxt[i].ovf = pp_s[i-1].ovf | mo[14] | mo[15] | u_c.ovf | v_c.ovf;
				end
				32: begin
					if (pp_s[i-1].behind) begin
						nxt[i].pu = 32'h7FFF_FFFF;
						nxt[i].pv = 32'h7FFF_FFFF;
						nxt[i].st = ldp_pkg::ST_BEHIND;
					end else begin
						nxt[i].pu = pu_c;
						nxt[i].pv = pv_c;
						nxt[i].st = (pp_s[i-1].ovf || !fit_u || !fit_v) ?
							ldp_pkg::ST_SAT : ldp_pkg::ST_OK;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NPOST; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= div_o.valid;
			for (int i = 2; i <= NPOST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 1; i <= NPOST; i++) begin
				pp_s[i] <= nxt[i];
			end
		end
	end

	// Output register with one skid word behind it.
	assign out_load = !out_valid_q || !out_stall;
	assign emit = en && vld_s[NPOST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (emit) begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_load) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_load) begin
				pixel_u_q <= skid_u_q;
				pixel_v_q <= skid_v_q;
				status_q <= skid_st_q;
			end
		end else if (emit) begin
			if (out_load) begin
				pixel_u_q <= pp_s[NPOST].pu;
				pixel_v_q <= pp_s[NPOST].pv;
				status_q <= pp_s[NPOST].st;
			end else begin
				skid_u_q <= pp_s[NPOST].pu;
				skid_v_q <= pp_s[NPOST].pv;
				skid_st_q <= pp_s[NPOST].st;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_u = pixel_u_q;
	assign pixel_v = pixel_v_q;
	assign status = status_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held without a word in the output register");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_stall |=> skid_valid_q)
		else $error("skid word dropped while the output was stalled");

	a_behind_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ldp_pkg::ST_BEHIND |->
		pixel_u == 32'sh7FFF_FFFF && pixel_v == 32'sh7FFF_FFFF)
		else $error("behind-camera word without saturated pixels");

	a_no_emit_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !emit)
		else $error("pipeline advanced while the skid word was occupied");
`endif

endmodule

[rtl/core/ldp_div.sv]
// Pipelined restoring divider producing x/z and y/z in signed Q.28, one quotient bit per stage.
module ldp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	input  logic signed [31:0] z,
	output ldp_pkg::div_out_t  res
);

	localparam int NB = ldp_pkg::NUM_W;
	localparam int RW = ldp_pkg::REM_W;

	logic              vld_s [NB];
	ldp_pkg::div_tag_t tag_s [NB];
	logic [RW-1:0]     rx_s  [NB];
	logic [RW-1:0]     ry_s  [NB];
	logic [NB-1:0]     nx_s  [NB];
	logic [NB-1:0]     ny_s  [NB];
	logic [RW-1:0]     d_s   [NB];

	ldp_pkg::div_tag_t tag_in;
	logic [31:0]       ax;
	logic [31:0]       ay;
	logic              valid_q;
	logic              behind_q;
	ldp_pkg::q_t       xn_q;
	ldp_pkg::q_t       yn_q;

	// A point at or behind the camera plane still flows through; its quotient is ignored.
	assign tag_in.behind = z[31] || (z == 32'sd0);
	assign tag_in.xneg = x[31];
	assign tag_in.yneg = y[31];
	assign ax = x[31] ? 32'(-x) : 32'(x);
	assign ay = y[31] ? 32'(-y) : 32'(y);

	for (genvar i = 0; i < NB; i++) begin : g_stage
		logic              v_in;
		ldp_pkg::div_tag_t t_in;
		logic [RW-1:0]     rx_in;
		logic [RW-1:0]     ry_in;
		logic [NB-1:0]     nx_in;
		logic [NB-1:0]     ny_in;
		logic [RW-1:0]     d_in;
		ldp_pkg::dstep_t   sx;
		ldp_pkg::dstep_t   sy;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign t_in = tag_in;
			assign rx_in = '0;
			assign ry_in = '0;
			assign nx_in = {ax, {ldp_pkg::FRAC_W{1'b0}}};
			assign ny_in = {ay, {ldp_pkg::FRAC_W{1'b0}}};
			assign d_in = z[RW-1:0];
		end else begin : g_next
			assign v_in = vld_s[i-1];
			assign t_in = tag_s[i-1];
			assign rx_in = rx_s[i-1];
			assign ry_in = ry_s[i-1];
			assign nx_in = nx_s[i-1];
			assign ny_in = ny_s[i-1];
			assign d_in = d_s[i-1];
		end

		assign sx = ldp_pkg::div_step(rx_in, nx_in, d_in);
		assign sy = ldp_pkg::div_step(ry_in, ny_in, d_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[i] <= t_in;
				rx_s[i] <= sx.rem;
				ry_s[i] <= sy.rem;
				nx_s[i] <= sx.num;
				ny_s[i] <= sy.num;
				d_s[i] <= d_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vld_s[NB-1];
		end
	end

	// Quotient magnitude truncates toward zero; the sign of x or y is put back here.
	always_ff @(posedge clk) begin
		if (en) begin
			behind_q <= tag_s[NB-1].behind;
			xn_q <= tag_s[NB-1].xneg ? -ldp_pkg::q_t'(nx_s[NB-1]) : ldp_pkg::q_t'(nx_s[NB-1]);
			yn_q <= tag_s[NB-1].yneg ? -ldp_pkg::q_t'(ny_s[NB-1]) : ldp_pkg::q_t'(ny_s[NB-1]);
		end
	end

	assign res.valid = valid_q;
	assign res.behind = behind_q;
	assign res.xn = xn_q;
	assign res.yn = yn_q;

endmodule

[rtl/core/ldp_mul.sv]
// Four-stage saturating sign-magnitude multiplier built from 32x32 partial products.
module ldp_mul (
	input  logic        clk,
	input  logic        en,
	input  logic        wide,
	input  ldp_pkg::q_t a,
	input  ldp_pkg::q_t b,
	output ldp_pkg::q_t p,
	output logic        ovf
);

	logic         neg_s1;
	logic [63:0]  ma_s1;
	logic [63:0]  mb_s1;
	logic         neg_s2;
	logic [63:0]  p00_s2;
	logic [63:0]  p01_s2;
	logic [63:0]  p10_s2;
	logic [63:0]  p11_s2;
	logic         neg_s3;
	logic [127:0] prod_s3;
	logic [127:0] shifted;
	logic         over;
	ldp_pkg::q_t  mag;
	ldp_pkg::q_t  p_s4;
	logic         ovf_s4;

	// wide selects a shift of 32 instead of 28 for the focal length scaling.
	assign shifted = wide ? (prod_s3 >> 32) : (prod_s3 >> ldp_pkg::FRAC_W);
	assign over = |shifted[127:62];
	assign mag = over ? ldp_pkg::LIM : ldp_pkg::q_t'({2'b00, shifted[61:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[63] ^ b[63];
			ma_s1 <= a[63] ? 64'(-a) : 64'(a);
			mb_s1 <= b[63] ? 64'(-b) : 64'(b);
			neg_s2 <= neg_s1;
			p00_s2 <= 64'(ma_s1[31:0]) * 64'(mb_s1[31:0]);
			p01_s2 <= 64'(ma_s1[31:0]) * 64'(mb_s1[63:32]);
			p10_s2 <= 64'(ma_s1[63:32]) * 64'(mb_s1[31:0]);
			p11_s2 <= 64'(ma_s1[63:32]) * 64'(mb_s1[63:32]);
			neg_s3 <= neg_s2;
			prod_s3 <= 128'(p00_s2) + (128'(p01_s2) << 32) + (128'(p10_s2) << 32)
				+ (128'(p11_s2) << 64);
			p_s4 <= neg_s3 ? -mag : mag;
			ovf_s4 <= over;
		end
	end

	assign p = p_s4;
	assign ovf = ovf_s4;

endmodule
